@@ hw/rtl/flash_logical_block_mapper_macros.svh @@
// Assertion helpers for the flash logical block mapper.
// Each macro places one labeled concurrent assertion on the given clock and
// active-low reset; the synthesis variant expands to nothing.
`ifndef FLASH_LOGICAL_BLOCK_MAPPER_MACROS_SVH
`define FLASH_LOGICAL_BLOCK_MAPPER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define FLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flm assertion failed");

// Next-cycle implication
`define FLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flm assertion failed");

`else

`define FLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define FLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/flm_pkg.sv @@
package flm_pkg;

    // Request codes
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_ERASE  = 2'd2;
    localparam logic [1:0] CMD_HEADER = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_HEADER = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Partition codes
    localparam logic [2:0] PART_FACTORY  = 3'd0;
    localparam logic [2:0] PART_RESERVED = 3'd1;
    localparam logic [2:0] PART_USER     = 3'd2;
    localparam logic [2:0] PART_GAME     = 3'd3;
    localparam logic [2:0] PART_DEVICE   = 3'd4;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int ID_W   = 16;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 10;
    localparam int ADDR_W = 17;
    localparam int PART_W = 3;

    // 64-byte blocks
    localparam int BLOCK_SHIFT = 6;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SLOT_W-1:0] t_slot;

    // Flash byte offset of the partition header
    function automatic t_addr part_offset(input logic [PART_W-1:0] p);
        t_addr off;
        case (p)
            PART_FACTORY:  off = 17'h1a000;
            PART_RESERVED: off = 17'h18000;
            PART_USER:     off = 17'h1c000;
            PART_GAME:     off = 17'h10000;
            default:       off = 17'h00000;
        endcase
        return off;
    endfunction

    // Data slots: size/64 minus bitmap blocks minus the header block
    function automatic t_slot part_usable(input logic [PART_W-1:0] p);
        t_slot n;
        case (p)
            PART_FACTORY:  n = 10'd126;
            PART_RESERVED: n = 10'd126;
            PART_USER:     n = 10'd254;
            PART_GAME:     n = 10'd510;
            default:       n = 10'd1021;
        endcase
        return n;
    endfunction

endpackage

@@ hw/rtl/flash_logical_block_mapper.sv @@
// Flash logical block mapper. A request is taken when start is high and busy
// is low; its result appears on the o_ result ports for exactly one cycle with
// o_strobe high, and the receiver cannot stall it. Erase, header write, any
// request while no header is present, and a read or write with no allocated
// slot in range finish without a scan: the strobe follows the accepting edge.
// Other reads and writes scan the slot table from the highest allocated slot
// in range downward, one slot per cycle through the table's single read port,
// and stop at the first match; the scan starts at limit, the smaller of the
// allocated count and the usable slots of the selected partition. The slot
// table needs no clearing after reset. The partition register may be written
// whenever no request is in flight; values above 4 are ignored.
`include "flash_logical_block_mapper_macros.svh"

module flash_logical_block_mapper #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic [flm_pkg::CMD_W-1:0]     i_cmd,
    input  logic [flm_pkg::ID_W-1:0]      i_block_id,
    // result channel
    output logic                          o_strobe,
    output logic [flm_pkg::STAT_W-1:0]    o_status,
    output logic [flm_pkg::SLOT_W-1:0]    o_phys_slot,
    output logic [flm_pkg::ADDR_W-1:0]    o_byte_address,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [flm_pkg::PART_W-1:0]    i_cfg_partition
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam logic [flm_pkg::SLOT_W-1:0] MAX_USE = flm_pkg::SLOT_W'(MAX_SLOTS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                          r_state,     n_state;
    logic [flm_pkg::PART_W-1:0]    r_partition;
    logic [AW-1:0]                 r_used,      n_used;
    logic                          r_hdr,       n_hdr;
    logic [flm_pkg::CMD_W-1:0]     r_cmd,       n_cmd;
    logic [flm_pkg::ID_W-1:0]      r_id,        n_id;
    logic [AW-1:0]                 r_scan_addr, n_scan_addr;
    logic [AW-1:0]                 r_cmp_slot,  n_cmp_slot;
    logic                          r_strobe,    n_strobe;
    logic [flm_pkg::STAT_W-1:0]    r_status,    n_status;
    logic [flm_pkg::SLOT_W-1:0]    r_slot,      n_slot;
    logic [flm_pkg::ADDR_W-1:0]    r_addr,      n_addr;

    logic                          accept;
    logic [flm_pkg::ADDR_W-1:0]    offset;
    logic [flm_pkg::SLOT_W-1:0]    usable_raw;
    logic [AW-1:0]                 usable;
    logic [AW-1:0]                 limit;
    logic                          full;
    logic [AW-1:0]                 alloc_slot;
    logic                          finish;
    logic                          hit;
    logic [AW-1:0]                 hit_slot;
    logic [flm_pkg::CMD_W-1:0]     cur_cmd;
    logic [flm_pkg::ID_W-1:0]      cur_id;

    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [flm_pkg::ID_W-1:0]      rd_data;
    logic                          wr_en;

    // Partition geometry
    assign offset     = flm_pkg::part_offset(r_partition);
    assign usable_raw = flm_pkg::part_usable(r_partition);
    assign usable     = (usable_raw > MAX_USE) ? AW'(MAX_USE) : AW'(usable_raw);
    assign limit      = (r_used < usable) ? r_used : usable;
    assign full       = (r_used >= usable);
    assign alloc_slot = r_used + AW'(1);

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Request fields: live on the accepting cycle, held while scanning
    assign cur_cmd = (r_state == ST_IDLE) ? i_cmd      : r_cmd;
    assign cur_id  = (r_state == ST_IDLE) ? i_block_id : r_id;

    flm_slot_store #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (alloc_slot),
        .i_wr_data (cur_id)
    );

    // Sequence the lookup and form the result
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_hdr       = r_hdr;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_scan_addr = r_scan_addr;
        n_cmp_slot  = r_cmp_slot;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_slot      = r_slot;
        n_addr      = r_addr;
        rd_en       = 1'b0;
        rd_addr     = r_scan_addr;
        wr_en       = 1'b0;
        finish      = 1'b0;
        hit         = 1'b0;
        hit_slot    = r_cmp_slot;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    n_id  = i_block_id;
                    case (i_cmd)
                        flm_pkg::CMD_ERASE: begin
                            n_used   = '0;
                            n_hdr    = 1'b0;
                            n_strobe = 1'b1;
                            n_status = flm_pkg::ST_OK;
                            n_slot   = '0;
                            n_addr   = offset;
                        end
                        flm_pkg::CMD_HEADER: begin
                            n_hdr    = 1'b1;
                            n_strobe = 1'b1;
                            n_status = flm_pkg::ST_OK;
                            n_slot   = '0;
                            n_addr   = offset;
                        end
                        default: begin
                            if (!r_hdr) begin
                                n_strobe = 1'b1;
                                n_status = flm_pkg::ST_NO_HEADER;
                                n_slot   = '0;
                                n_addr   = '0;
                            end else if (limit == '0) begin
                                finish = 1'b1;
                            end else begin
                                // issue the read of the highest slot in range
                                rd_en       = 1'b1;
                                rd_addr     = limit;
                                n_cmp_slot  = limit;
                                n_scan_addr = limit - AW'(1);
                                n_state     = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (rd_data == r_id) begin
                    finish = 1'b1;
                    hit    = 1'b1;
                end else if (r_scan_addr != '0) begin
                    // advance one slot downward
                    rd_en       = 1'b1;
                    rd_addr     = r_scan_addr;
                    n_cmp_slot  = r_scan_addr;
                    n_scan_addr = r_scan_addr - AW'(1);
                end else begin
                    finish = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Resolve a lookup: hit, allocate, full or not found
        if (finish) begin
            n_state  = ST_IDLE;
            n_strobe = 1'b1;
            if (hit) begin
                n_status = flm_pkg::ST_OK;
                n_slot   = flm_pkg::SLOT_W'(hit_slot);
                n_addr   = offset + (flm_pkg::ADDR_W'(hit_slot) << flm_pkg::BLOCK_SHIFT);
            end else if (cur_cmd == flm_pkg::CMD_WRITE && !full) begin
                wr_en    = 1'b1;
                n_used   = alloc_slot;
                n_status = flm_pkg::ST_OK;
                n_slot   = flm_pkg::SLOT_W'(alloc_slot);
                n_addr   = offset + (flm_pkg::ADDR_W'(alloc_slot) << flm_pkg::BLOCK_SHIFT);
            end else begin
                n_status = (cur_cmd == flm_pkg::CMD_WRITE) ? flm_pkg::ST_FULL
                                                           : flm_pkg::ST_NOT_FOUND;
                n_slot   = '0;
                n_addr   = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_hdr       <= 1'b0;
            r_strobe    <= 1'b0;
            r_partition <= flm_pkg::PART_FACTORY;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_hdr    <= n_hdr;
            r_strobe <= n_strobe;
            // drop partition codes beyond the whole device
            if (i_cfg_valid && o_cfg_ready && i_cfg_partition <= flm_pkg::PART_DEVICE) begin
                r_partition <= i_cfg_partition;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_id        <= n_id;
        r_scan_addr <= n_scan_addr;
        r_cmp_slot  <= n_cmp_slot;
        r_status    <= n_status;
        r_slot      <= n_slot;
        r_addr      <= n_addr;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_phys_slot    = r_slot;
    assign o_byte_address = r_addr;

    // Checks
    `FLM_ASSERT_IMP(a_scan_no_strobe, i_clk, i_rst_n, r_state == ST_SCAN, !r_strobe)
    `FLM_ASSERT_IMP(a_scan_in_prefix, i_clk, i_rst_n, r_state == ST_SCAN,
                    r_cmp_slot <= r_used && r_cmp_slot != '0)
    `FLM_ASSERT_NXT(a_erase_clears, i_clk, i_rst_n, accept && i_cmd == flm_pkg::CMD_ERASE,
                    r_strobe && r_used == '0 && !r_hdr && r_status == flm_pkg::ST_OK)
    `FLM_ASSERT_NXT(a_no_header, i_clk, i_rst_n,
                    accept && !r_hdr && (i_cmd == flm_pkg::CMD_READ ||
                    i_cmd == flm_pkg::CMD_WRITE),
                    r_strobe && r_status == flm_pkg::ST_NO_HEADER && $stable(r_used))

endmodule

@@ hw/rtl/flm_slot_store.sv @@
module flm_slot_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [flm_pkg::ID_W-1:0]  o_rd_data,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [flm_pkg::ID_W-1:0]  i_wr_data
);

    logic [flm_pkg::ID_W-1:0] r_mem [DEPTH];
    logic [flm_pkg::ID_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
